@@ design/location_table_span_decoder_assert.svh @@
// Assertion helpers shared by the span decoder modules.
`ifndef LOCATION_TABLE_SPAN_DECODER_ASSERT_SVH
`define LOCATION_TABLE_SPAN_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lts_pkg.sv @@
`timescale 1ns / 1ps

package lts_pkg;

    // Header byte layout
    localparam int HDR_FLAG_BIT = 7;
    localparam int CONT_BIT     = 6;

    // Form codes
    localparam logic [3:0] FORM_NONE     = 4'd15;
    localparam logic [3:0] FORM_LONG     = 4'd14;
    localparam logic [3:0] FORM_LINE     = 4'd13;
    localparam logic [3:0] FORM_ONE_BASE = 4'd10;

    // Varint shift: last in-range position and the saturated "past the top" mark
    localparam logic [4:0] SHIFT_LAST = 5'd30;
    localparam logic [4:0] SHIFT_SAT  = 5'd31;
    localparam logic [4:0] SHIFT_STEP = 5'd6;

    // Value for an unknown line or column
    localparam logic [31:0] UNKNOWN = 32'hFFFF_FFFF;

    // Configuration space
    localparam int         ADDR_W         = 3;
    localparam logic       REG_FIRST_LINE = 1'b0;

    typedef struct packed {
        logic [30:0] start_offset;
        logic [30:0] end_offset;
        logic [31:0] span_line;
        logic [31:0] span_end_line;
        logic [31:0] start_column;
        logic [31:0] end_column;
    } span_t;

endpackage

@@ design/lts_apb_regs.sv @@
`timescale 1ns / 1ps

module lts_apb_regs
    import lts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [30:0]       first_line
);

    logic [30:0] first_line_reg;
    logic        wr_transfer;

    // Register index is the word address; byte lanes within a word are ignored
    assign wr_transfer = psel && penable && pwrite;
    assign pready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_line_reg <= '0;
        end
        else if (wr_transfer && (paddr[ADDR_W-1] == REG_FIRST_LINE))
        begin
            first_line_reg <= pwdata[30:0];
        end
    end

    // Read mux
    always_comb
    begin
        case (paddr[ADDR_W-1])
            REG_FIRST_LINE: prdata = {1'b0, first_line_reg};
            default:        prdata = '0;
        endcase
    end

    assign first_line = first_line_reg;

endmodule

@@ design/lts_core.sv @@
`timescale 1ns / 1ps
`include "location_table_span_decoder_assert.svh"

module lts_core
    import lts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  byte_in,
    input  logic        start_in,
    input  logic [30:0] first_line,
    output logic        emit,
    output span_t       span
);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_LONG_LINE,
        PH_LONG_ENDL,
        PH_LONG_SCOL,
        PH_LONG_ECOL,
        PH_LINE_ONLY,
        PH_ONE_SCOL,
        PH_ONE_ECOL,
        PH_SHORT
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [31:0] line_reg, line_next, line_cur;
    logic [30:0] cu_reg, cu_next, cu_cur;
    logic [3:0]  form_reg, form_next;
    logic [3:0]  len_reg, len_next, emit_len;
    logic [31:0] acc_reg, acc_next, acc_cur;
    logic [4:0]  shift_reg, shift_next, shift_cur;
    logic [31:0] eline_reg, eline_next;
    logic [31:0] scol_reg, scol_next;
    logic        stop_reg, stop_next, stop_cur;

    logic [31:0] acc_merged;
    logic        vdone;
    logic [31:0] vval;
    logic [31:0] vmag;
    logic [31:0] vsigned;
    logic [31:0] line_plus_sd;
    logic [6:0]  short_scol;
    logic [31:0] short_ecol;
    logic [30:0] end_cu;

    // Table start resets line, offset, stop flag and entry decoding first
    always_comb
    begin
        line_cur  = start_in ? {1'b0, first_line} : line_reg;
        cu_cur    = start_in ? '0 : cu_reg;
        stop_cur  = start_in ? 1'b0 : stop_reg;
        phase_cur = start_in ? PH_HEADER : phase_reg;
        acc_cur   = start_in ? '0 : acc_reg;
        shift_cur = start_in ? '0 : shift_reg;
    end

    // Varint byte: merge the 6-bit chunk, drop bits past the top
    assign acc_merged   = (shift_cur <= SHIFT_LAST)
                          ? (acc_cur | ({26'd0, byte_in[5:0]} << shift_cur)) : acc_cur;
    assign vdone        = !byte_in[CONT_BIT];
    assign vval         = acc_merged;
    assign vmag         = {1'b0, vval[31:1]};
    assign vsigned      = vval[0] ? (32'd0 - vmag) : vmag;
    assign line_plus_sd = line_cur + vsigned;

    // Short form columns
    assign short_scol = {form_reg, byte_in[6:4]};
    assign short_ecol = {25'd0, short_scol} + {28'd0, byte_in[3:0]};

    // Per-byte step
    always_comb
    begin
        phase_next = phase_cur;
        line_next  = line_cur;
        form_next  = form_reg;
        len_next   = len_reg;
        acc_next   = acc_cur;
        shift_next = shift_cur;
        eline_next = eline_reg;
        scol_next  = scol_reg;
        stop_next  = stop_cur;
        emit       = 1'b0;
        emit_len   = len_reg;
        span.span_line     = line_cur;
        span.span_end_line = line_cur;
        span.start_column  = UNKNOWN;
        span.end_column    = UNKNOWN;

        // varint bookkeeping in varint phases
        if (phase_cur == PH_LONG_LINE || phase_cur == PH_LONG_ENDL ||
            phase_cur == PH_LONG_SCOL || phase_cur == PH_LONG_ECOL ||
            phase_cur == PH_LINE_ONLY)
        begin
            if (vdone)
            begin
                acc_next   = '0;
                shift_next = '0;
            end
            else
            begin
                acc_next   = acc_merged;
                shift_next = (shift_cur < SHIFT_LAST) ? shift_cur + SHIFT_STEP : SHIFT_SAT;
            end
        end

        if (!stop_cur)
        begin
            case (phase_cur)
                PH_HEADER:
                begin
                    if (!byte_in[HDR_FLAG_BIT])
                    begin
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        form_next  = byte_in[6:3];
                        len_next   = {1'b0, byte_in[2:0]} + 4'd1;
                        emit_len   = len_next;
                        acc_next   = '0;
                        shift_next = '0;
                        if (form_next == FORM_NONE)
                        begin
                            emit               = 1'b1;
                            span.span_line     = UNKNOWN;
                            span.span_end_line = UNKNOWN;
                        end
                        else if (form_next == FORM_LONG)
                        begin
                            phase_next = PH_LONG_LINE;
                        end
                        else if (form_next == FORM_LINE)
                        begin
                            phase_next = PH_LINE_ONLY;
                        end
                        else if (form_next >= FORM_ONE_BASE)
                        begin
                            line_next  = line_cur + {28'd0, form_next - FORM_ONE_BASE};
                            phase_next = PH_ONE_SCOL;
                        end
                        else
                        begin
                            phase_next = PH_SHORT;
                        end
                    end
                end
                PH_LONG_LINE:
                begin
                    if (vdone)
                    begin
                        line_next  = line_plus_sd;
                        phase_next = PH_LONG_ENDL;
                    end
                end
                PH_LONG_ENDL:
                begin
                    if (vdone)
                    begin
                        eline_next = line_cur + vval;
                        phase_next = PH_LONG_SCOL;
                    end
                end
                PH_LONG_SCOL:
                begin
                    if (vdone)
                    begin
                        scol_next  = vval - 32'd1;
                        phase_next = PH_LONG_ECOL;
                    end
                end
                PH_LONG_ECOL:
                begin
                    if (vdone)
                    begin
                        emit               = 1'b1;
                        span.span_end_line = eline_reg;
                        span.start_column  = scol_reg;
                        span.end_column    = vval - 32'd1;
                    end
                end
                PH_LINE_ONLY:
                begin
                    if (vdone)
                    begin
                        emit               = 1'b1;
                        line_next          = line_plus_sd;
                        span.span_line     = line_plus_sd;
                        span.span_end_line = line_plus_sd;
                    end
                end
                PH_ONE_SCOL:
                begin
                    scol_next  = {24'd0, byte_in};
                    phase_next = PH_ONE_ECOL;
                end
                PH_ONE_ECOL:
                begin
                    emit              = 1'b1;
                    span.start_column = scol_reg;
                    span.end_column   = {24'd0, byte_in};
                end
                PH_SHORT:
                begin
                    emit              = 1'b1;
                    span.start_column = {25'd0, short_scol};
                    span.end_column   = short_ecol;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        // Offsets of the completed entry; a completed entry advances the count
        end_cu  = cu_cur + {27'd0, emit_len};
        cu_next = cu_cur;
        if (emit)
        begin
            cu_next    = end_cu;
            phase_next = PH_HEADER;
        end
        span.start_offset = {cu_cur[29:0], 1'b0};
        span.end_offset   = {end_cu[29:0], 1'b0};
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            line_reg  <= '0;
            cu_reg    <= '0;
            form_reg  <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            shift_reg <= '0;
            eline_reg <= '0;
            scol_reg  <= '0;
            stop_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
            cu_reg    <= cu_next;
            form_reg  <= form_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            eline_reg <= eline_next;
            scol_reg  <= scol_next;
            stop_reg  <= stop_next;
        end
    end

    // Checks
    `LTS_ASSERT_NOW(a_stopped_silent, clk, rst_n, stop_reg && !start_in, !emit, "span emitted while stopped")
    `LTS_ASSERT_NOW(a_stop_in_header, clk, rst_n, stop_reg, phase_reg == PH_HEADER, "stopped outside header phase")
    `LTS_ASSERT_NOW(a_shift_legal, clk, rst_n, 1'b1, !shift_reg[0] || shift_reg == SHIFT_SAT, "bad varint shift")

endmodule

@@ design/location_table_span_decoder.sv @@
`timescale 1ns / 1ps
`include "location_table_span_decoder_assert.svh"

// Location table span decoder: takes one table byte per cycle on the table
// channel while the span side is not stalling and returns one span per completed
// entry on the span channel. A byte lands in an input register, is decoded there
// by the entry state machine and its span (if any) is loaded into a result
// register, from which it is offered. The sustained rate is one byte per clock,
// limited only by the step of the decoder; a stall on the span side holds at most
// one byte in the input register. first_line (APB, address 0) takes effect at the
// next byte flagged with table_start.
module location_table_span_decoder
    import lts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // table byte channel
    input  logic              table_valid,
    output logic              table_ready,
    input  logic [7:0]        table_byte,
    input  logic              table_start,
    // span channel
    output logic              span_valid,
    input  logic              span_ready,
    output logic [30:0]       start_offset,
    output logic [30:0]       end_offset,
    output logic signed [31:0] span_line,
    output logic signed [31:0] span_end_line,
    output logic signed [31:0] start_column,
    output logic signed [31:0] end_column,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg, out_valid_next;
    span_t       span_reg;
    span_t       span_step;
    logic        fire;
    logic        emit;
    logic [30:0] first_line;

    lts_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .first_line (first_line)
    );

    // Step when a byte is held and the result register is free or draining
    assign fire        = in_valid_reg && (!out_valid_reg || span_ready);
    assign table_ready = !in_valid_reg || fire;

    lts_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .byte_in    (in_byte_reg),
        .start_in   (in_start_reg),
        .first_line (first_line),
        .emit       (emit),
        .span       (span_step)
    );

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (table_valid && table_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (span_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (table_valid && table_ready)
        begin
            in_byte_reg  <= table_byte;
            in_start_reg <= table_start;
        end
        if (fire && emit)
        begin
            span_reg <= span_step;
        end
    end

    assign span_valid    = out_valid_reg;
    assign start_offset  = span_reg.start_offset;
    assign end_offset    = span_reg.end_offset;
    assign span_line     = span_reg.span_line;
    assign span_end_line = span_reg.span_end_line;
    assign start_column  = span_reg.start_column;
    assign end_column    = span_reg.end_column;

    // Checks
    `LTS_ASSERT_NEXT(a_emit_shown, clk, rst_n, fire && emit, span_valid, "decoded span not presented")
    `LTS_ASSERT_NOW(a_ready_hold, clk, rst_n, !table_ready, in_valid_reg && span_valid && !span_ready, "input blocked without stall")
    `LTS_ASSERT_NOW(a_span_len, clk, rst_n, span_valid, (end_offset - start_offset) >= 31'd2 && (end_offset - start_offset) <= 31'd16 && !end_offset[0] && !start_offset[0], "span length out of range")

endmodule

@@ test/location_table_span_decoder_tb.sv @@
`timescale 1ns / 1ps

module location_table_span_decoder_tb;
    import lts_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [ADDR_W-1:0] FIRST_LINE_ADDR = ADDR_W'(4 * REG_FIRST_LINE);
    localparam logic [3:0] FORM_SHORT_FIRST = 4'd0;
    localparam logic [3:0] FORM_SHORT_LAST = 4'd9;

    // Where the span predictor is inside an entry
    typedef enum logic [3:0] {
        AWAIT_HEADER,
        LONG_LINE,
        LONG_END_LINE,
        LONG_START_COL,
        LONG_END_COL,
        LINE_ONLY,
        ONE_START_COL,
        ONE_END_COL,
        SHORT_COLS
    } entry_step_e;

    logic clk;
    logic rst_n;
    logic table_valid;
    logic table_ready;
    logic [7:0] table_byte;
    logic table_start;
    logic span_valid;
    logic span_ready;
    logic [30:0] start_offset;
    logic [30:0] end_offset;
    logic signed [31:0] span_line;
    logic signed [31:0] span_end_line;
    logic signed [31:0] start_column;
    logic signed [31:0] end_column;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // Predictor state
    logic [30:0] cfg_first_line;
    logic [31:0] line_now;
    logic [30:0] units_done;
    entry_step_e entry_step;
    logic [3:0] form_now;
    logic [3:0] units_in_entry;
    logic [31:0] varint_acc;
    logic [4:0] varint_pos;
    logic [31:0] held_end_line;
    logic [31:0] held_start_col;
    logic halted;

    span_t expected_spans[$];

    int error_count;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    location_table_span_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .table_valid(table_valid),
        .table_ready(table_ready),
        .table_byte(table_byte),
        .table_start(table_start),
        .span_valid(span_valid),
        .span_ready(span_ready),
        .start_offset(start_offset),
        .end_offset(end_offset),
        .span_line(span_line),
        .span_end_line(span_end_line),
        .start_column(start_column),
        .end_column(end_column),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] header_byte(input logic [3:0] form, input logic [2:0] len_m1);
        return {1'b1, form, len_m1};
    endfunction

    // 6-bit little-endian varint; bits past the top are dropped
    function automatic logic varint_feed(input logic [7:0] b, output logic [31:0] value);
        value = '0;
        if (varint_pos <= SHIFT_LAST)
            varint_acc = varint_acc | (32'(b[5:0]) << varint_pos);
        if (b[CONT_BIT])
        begin
            varint_pos = (varint_pos < SHIFT_LAST) ? varint_pos + SHIFT_STEP : SHIFT_SAT;
            return 1'b0;
        end
        value = varint_acc;
        varint_acc = '0;
        varint_pos = '0;
        return 1'b1;
    endfunction

    // Sign in bit 0, magnitude above
    function automatic logic [31:0] signed_delta(input logic [31:0] u);
        return u[0] ? (32'd0 - (u >> 1)) : (u >> 1);
    endfunction

    task automatic push_span(input logic [31:0] line, input logic [31:0] eline,
                             input logic [31:0] scol, input logic [31:0] ecol);
        logic [30:0] end_units;
        span_t s;
        end_units = units_done + 31'(units_in_entry);
        s.start_offset = {units_done[29:0], 1'b0};
        s.end_offset = {end_units[29:0], 1'b0};
        s.span_line = line;
        s.span_end_line = eline;
        s.start_column = scol;
        s.end_column = ecol;
        expected_spans.insert(expected_spans.size(), s);
        units_done = end_units;
        entry_step = AWAIT_HEADER;
    endtask

    // Advance the predictor by one accepted table byte
    task automatic predict_byte(input logic [7:0] b, input logic st);
        logic [31:0] v;
        logic [31:0] sc;
        if (st)
        begin
            line_now = {1'b0, cfg_first_line};
            units_done = '0;
            halted = 1'b0;
            entry_step = AWAIT_HEADER;
            varint_acc = '0;
            varint_pos = '0;
        end
        if (halted)
            return;
        case (entry_step)
            LONG_LINE:
                if (varint_feed(b, v))
                begin
                    line_now = line_now + signed_delta(v);
                    entry_step = LONG_END_LINE;
                end
            LONG_END_LINE:
                if (varint_feed(b, v))
                begin
                    held_end_line = line_now + v;
                    entry_step = LONG_START_COL;
                end
            LONG_START_COL:
                if (varint_feed(b, v))
                begin
                    held_start_col = v - 32'd1;
                    entry_step = LONG_END_COL;
                end
            LONG_END_COL:
                if (varint_feed(b, v))
                    push_span(line_now, held_end_line, held_start_col, v - 32'd1);
            LINE_ONLY:
                if (varint_feed(b, v))
                begin
                    line_now = line_now + signed_delta(v);
                    push_span(line_now, line_now, UNKNOWN, UNKNOWN);
                end
            ONE_START_COL:
            begin
                held_start_col = 32'(b);
                entry_step = ONE_END_COL;
            end
            ONE_END_COL:
                push_span(line_now, line_now, held_start_col, 32'(b));
            SHORT_COLS:
            begin
                sc = 32'({form_now, 3'b000}) + 32'(b[6:4]);
                push_span(line_now, line_now, sc, sc + 32'(b[3:0]));
            end
            default:
            begin
                // header byte; bit 7 clear halts until the next table start
                if (!b[HDR_FLAG_BIT])
                begin
                    halted = 1'b1;
                    entry_step = AWAIT_HEADER;
                end
                else
                begin
                    form_now = b[6:3];
                    units_in_entry = {1'b0, b[2:0]} + 4'd1;
                    varint_acc = '0;
                    varint_pos = '0;
                    if (form_now == FORM_NONE)
                        push_span(UNKNOWN, UNKNOWN, UNKNOWN, UNKNOWN);
                    else if (form_now == FORM_LONG)
                        entry_step = LONG_LINE;
                    else if (form_now == FORM_LINE)
                        entry_step = LINE_ONLY;
                    else if (form_now >= FORM_ONE_BASE)
                    begin
                        line_now = line_now + 32'(form_now - FORM_ONE_BASE);
                        entry_step = ONE_START_COL;
                    end
                    else
                        entry_step = SHORT_COLS;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Predict on each table transfer, check each span transfer
    always @(posedge clk)
    begin
        span_t want;
        if (rst_n && table_valid && table_ready)
            predict_byte(table_byte, table_start);
        if (rst_n && span_valid && span_ready)
        begin
            if (expected_spans.size() == 0)
                report_mismatch("unexpected span, line", span_line, '0);
            else
            begin
                want = expected_spans.pop_front();
                if (start_offset !== want.start_offset)
                    report_mismatch("start_offset", 32'(start_offset), 32'(want.start_offset));
                if (end_offset !== want.end_offset)
                    report_mismatch("end_offset", 32'(end_offset), 32'(want.end_offset));
                if (span_line !== want.span_line)
                    report_mismatch("span_line", span_line, want.span_line);
                if (span_end_line !== want.span_end_line)
                    report_mismatch("span_end_line", span_end_line, want.span_end_line);
                if (start_column !== want.start_column)
                    report_mismatch("start_column", start_column, want.start_column);
                if (end_column !== want.end_column)
                    report_mismatch("end_column", end_column, want.end_column);
            end
        end
    end

    // Random backpressure on the span side
    always @(negedge clk)
        span_ready = ($urandom_range(0, 99) >= recv_idle_pct);

    // Watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (table_valid && table_ready) || (span_valid && span_ready)
            || (psel && penable))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic st);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            table_valid = 1'b0;
            @(negedge clk);
        end
        table_valid = 1'b1;
        table_byte = b;
        table_start = st;
        do
            @(posedge clk);
        while (!table_ready);
        items_sent++;
    endtask

    // Sender pauses until every pending span has come back
    task automatic wait_for_spans();
        @(negedge clk);
        table_valid = 1'b0;
        while (expected_spans.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle_block();
        wait_for_spans();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        table_valid = 1'b0;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == FIRST_LINE_ADDR)
            cfg_first_line = data[30:0];
    endtask

    task automatic check_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
        logic [31:0] got;
        @(negedge clk);
        table_valid = 1'b0;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = addr;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== want)
            report_mismatch("first_line readback", got, want);
    endtask

    task automatic set_first_line(input logic [30:0] value);
        settle_block();
        write_reg(FIRST_LINE_ADDR, {1'b0, value});
        check_reg(FIRST_LINE_ADDR, {1'b0, value});
    endtask

    // 1..3 byte varint, now and then a long one of 4..7 bytes that can run past bit 31
    task automatic send_varint();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
            send_byte({1'($urandom_range(0, 1)), (i < n - 1), 6'($urandom_range(0, 63))}, 1'b0);
    endtask

    // One well-formed entry with random content; optionally cut after the header
    task automatic send_entry(input logic st, input logic cut_short);
        int pick;
        logic [3:0] form;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            form = FORM_NONE;
        else if (pick < 28)
            form = FORM_LONG;
        else if (pick < 43)
            form = FORM_LINE;
        else if (pick < 60)
            form = FORM_ONE_BASE + 4'($urandom_range(0, 2));
        else
            form = 4'($urandom_range(FORM_SHORT_FIRST, FORM_SHORT_LAST));
        send_byte(header_byte(form, 3'($urandom_range(0, 7))), st);
        if (cut_short)
            return;
        if (form == FORM_LONG)
            repeat (4) send_varint();
        else if (form == FORM_LINE)
            send_varint();
        else if (form >= FORM_ONE_BASE && form != FORM_NONE)
            repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b0);
        else if (form != FORM_NONE)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_register_access();
        set_first_line(31'h7FFF_FFFF);
    endtask

    task automatic test_short_and_unknown();
        send_byte(header_byte(FORM_NONE, 3'd7), 1'b1);
        send_byte(header_byte(FORM_SHORT_FIRST, 3'd0), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(header_byte(FORM_SHORT_LAST, 3'd7), 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // One-line forms (line wraps past the top from first_line max) and line-only
    task automatic test_one_line_and_line_only();
        send_byte(header_byte(FORM_ONE_BASE, 3'd0), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(header_byte(FORM_ONE_BASE + 4'd2, 3'd3), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(header_byte(FORM_LINE, 3'd0), 1'b0);
        send_byte(8'h03, 1'b0);
    endtask

    // Long form with a varint that saturates the shift; start column encoded as zero, end column as one
    task automatic test_long_form();
        send_byte(header_byte(FORM_LONG, 3'd5), 1'b0);
        send_byte(8'h02, 1'b0);
        repeat (6) send_byte(8'h7F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Halt on a non-header byte, ignored bytes, partial entry dropped at table start
    task automatic test_stop_and_restart();
        send_byte(8'h00, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(header_byte(FORM_LONG, 3'd0), 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(header_byte(FORM_NONE, 3'd0), 1'b1);
    endtask

    task automatic test_random_tables(input int sender_pct, input int receiver_pct,
                                      input logic [30:0] line_base, input int item_goal);
        int goal_end;
        int pick;
        logic new_table;
        set_first_line(line_base);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        goal_end = items_sent + item_goal;
        new_table = 1'b1;
        while (items_sent < goal_end)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                wait_for_spans();
            else if (pick < 8)
            begin
                // halt, then a few bytes that must be ignored
                send_byte(8'($urandom_range(0, 127)), new_table);
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                new_table = 1'b1;
            end
            else if (pick < 12)
            begin
                send_byte(8'($urandom_range(0, 255)), new_table);
                new_table = 1'($urandom_range(0, 1));
            end
            else
            begin
                send_entry(new_table, pick < 16);
                new_table = (pick < 16) || ($urandom_range(0, 19) == 0);
            end
        end
    endtask

    initial
    begin
        error_count = 0;
        items_sent = 0;
        quiet_cycles = 0;
        send_idle_pct = 29;
        recv_idle_pct = 84;
        table_valid = 1'b0;
        table_byte = '0;
        table_start = 1'b0;
        span_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_first_line = '0;
        line_now = '0;
        units_done = '0;
        entry_step = AWAIT_HEADER;
        form_now = '0;
        units_in_entry = '0;
        varint_acc = '0;
        varint_pos = '0;
        held_end_line = '0;
        held_start_col = '0;
        halted = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_access();
        test_short_and_unknown();
        test_one_line_and_line_only();
        test_long_form();
        test_stop_and_restart();
        test_random_tables(29, 84, 31'($urandom), 160);
        test_random_tables(84, 29, 31'd0, 160);
        test_random_tables(0, 0, 31'($urandom), 160);

        wait_for_spans();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/lts_pkg.sv
design/lts_apb_regs.sv
design/lts_core.sv
design/location_table_span_decoder.sv
test/location_table_span_decoder_tb.sv
